// ----- design/dtr_pkg.sv -----
// Shared types, constants and helpers for the divider/timer block.
`timescale 1ns / 1ps

package dtr_pkg;

    localparam logic [15:0] SYS_RESET         = 16'h1800;
    localparam logic [7:0]  CONTROL_RESET_RAW = 8'hF8;
    localparam logic [2:0]  CONTROL_RESET     = CONTROL_RESET_RAW[2:0];
    localparam logic [1:0]  RELOAD_DELAY      = 2'd3;
    localparam logic [1:0]  WRITE_BLOCK_TICKS = 2'd3;

    localparam logic [3:0]  TAP_BIT9 = 4'd9;
    localparam logic [3:0]  TAP_BIT3 = 4'd3;
    localparam logic [3:0]  TAP_BIT5 = 4'd5;
    localparam logic [3:0]  TAP_BIT7 = 4'd7;

    typedef enum logic [1:0] {
        SEL_BIT9 = 2'd0,
        SEL_BIT3 = 2'd1,
        SEL_BIT5 = 2'd2,
        SEL_BIT7 = 2'd3
    } dtr_sel_t;

    typedef struct packed {
        logic       divider_clear;
        logic       count_write;
        logic [7:0] count_data;
        logic       modulo_write;
        logic [7:0] modulo_data;
        logic       control_write;
        logic [2:0] control_data;
    } dtr_in_t;

    typedef struct packed {
        logic [7:0] divider_value;
        logic [7:0] count_value;
        logic       timer_irq;
    } dtr_out_t;

    typedef struct packed {
        logic [15:0] system_counter;
        logic [7:0]  timer_count;
        logic [7:0]  reload_modulo;
        logic [2:0]  control_now;
        logic [2:0]  control_before;
        logic [1:0]  overflow_delay;
        logic [1:0]  write_block_count;
    } dtr_state_t;

    // control[1:0] picks which system counter bit clocks the timer
    function automatic logic [3:0] tap_index(input logic [1:0] sel);
        logic [3:0] idx;
        case (dtr_sel_t'(sel))
            SEL_BIT9: idx = TAP_BIT9;
            SEL_BIT3: idx = TAP_BIT3;
            SEL_BIT5: idx = TAP_BIT5;
            SEL_BIT7: idx = TAP_BIT7;
            default:  idx = TAP_BIT9;
        endcase
        return idx;
    endfunction

endpackage

// ----- design/dtr_in_stage.sv -----
// Input register stage: holds one accepted word until the tick logic takes it.
`timescale 1ns / 1ps

module dtr_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  dtr_pkg::dtr_in_t s_data,
    output logic            q_valid,
    input  logic            q_take,
    output dtr_pkg::dtr_in_t q_data
);
    import dtr_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    dtr_in_t data_reg;

    assign s_ready = !valid_reg || q_take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !q_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign q_valid = valid_reg;
    assign q_data  = data_reg;

endmodule

// ----- design/dtr_step.sv -----
// One timer tick: next state and the result word from current state and input.
`timescale 1ns / 1ps

module dtr_step (
    input  dtr_pkg::dtr_state_t cur,
    input  dtr_pkg::dtr_in_t    word,
    output dtr_pkg::dtr_state_t nxt,
    output dtr_pkg::dtr_out_t   res
);
    import dtr_pkg::*;

    logic [15:0] sys_base;
    logic [15:0] sys_new;
    logic [7:0]  modulo;
    logic [2:0]  ctl;
    logic        cnt_wr;
    logic [1:0]  od_dec;
    logic        reload;
    logic        old_high;
    logic        new_high;
    logic        advance;
    logic [7:0]  tc;
    logic [1:0]  od;
    logic [1:0]  wb;

    always_comb begin
        modulo   = word.modulo_write  ? word.modulo_data  : cur.reload_modulo;
        ctl      = word.control_write ? word.control_data : cur.control_now;
        sys_base = word.divider_clear ? 16'd0 : cur.system_counter;
        sys_new  = sys_base + 16'd1;

        // count writes are dropped while the post-reload block is running
        cnt_wr = word.count_write && (cur.write_block_count == 2'd0);
        wb     = (cur.write_block_count != 2'd0) ? cur.write_block_count - 2'd1
                                                 : cur.write_block_count;

        od_dec = cur.overflow_delay - 2'd1;
        reload = (cur.overflow_delay != 2'd0) && (od_dec == 2'd0);
        od     = (cur.overflow_delay != 2'd0) ? od_dec : 2'd0;

        new_high = sys_new[tap_index(ctl[1:0])];
        old_high = cur.system_counter[tap_index(cur.control_before[1:0])];
        if (ctl[2]) begin
            advance = old_high && !new_high;
        end else begin
            // turning the enable off while the tap is high counts once
            advance = cur.control_before[2] && new_high;
        end

        tc = cur.timer_count;
        if (reload) begin
            tc = modulo;
            wb = WRITE_BLOCK_TICKS;
        end else if (advance) begin
            tc = cur.timer_count + 8'd1;
        end

        if (cnt_wr) begin
            tc = word.count_data;
            od = 2'd0;
        end else if (cur.timer_count[7] && !tc[7]) begin
            od = RELOAD_DELAY;
        end

        nxt.system_counter    = sys_new;
        nxt.timer_count       = tc;
        nxt.reload_modulo     = modulo;
        nxt.control_now       = ctl;
        nxt.control_before    = ctl;
        nxt.overflow_delay    = od;
        nxt.write_block_count = wb;

        res.divider_value = sys_new[15:8];
        res.count_value   = tc;
        res.timer_irq     = reload;
    end

endmodule

// ----- design/divider_timer_with_reload_core.sv -----
// Top level: divider and timer with delayed reload, word in and word out.
// Path: an accepted word waits in the input register; its result is then written to the
// result register and held there until taken, so a busy result side stalls the input.
// Throughput: one word per cycle while results are taken; between the registers sit a
// 16-bit and an 8-bit increment plus muxes. The input frees when the result is taken or empty.
// Reset (aresetn low, synchronous): pipeline empties, system counter to 0x1800,
// all timer, modulo, control, delay and block state to zero.
`timescale 1ns / 1ps

module divider_timer_with_reload_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dtr_pkg::dtr_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output dtr_pkg::dtr_out_t m_data
);
    import dtr_pkg::*;

    logic       q_valid;
    logic       q_take;
    dtr_in_t    q_data;
    dtr_state_t state_reg;
    dtr_state_t state_next;
    dtr_out_t   res;
    dtr_out_t   out_reg;
    logic       out_valid_reg;
    logic       out_valid_next;

    dtr_in_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_take  (q_take),
        .q_data  (q_data)
    );

    dtr_step u_step (
        .cur  (state_reg),
        .word (q_data),
        .nxt  (state_next),
        .res  (res)
    );

    // a held word is processed once the result slot is free or draining
    assign q_take = q_valid && (!out_valid_reg || m_ready);
    assign out_valid_next = q_take || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg             <= 1'b0;
            state_reg.system_counter    <= SYS_RESET;
            state_reg.timer_count       <= 8'd0;
            state_reg.reload_modulo     <= 8'd0;
            state_reg.control_now       <= CONTROL_RESET;
            state_reg.control_before    <= CONTROL_RESET;
            state_reg.overflow_delay    <= 2'd0;
            state_reg.write_block_count <= 2'd0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (q_take) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_take) begin
            out_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ----- dv/tb.sv -----
// Testbench for divider_timer_with_reload_core: directed table, random ticks, predictor check.
`timescale 1ns / 1ps

module tb;
    import dtr_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          HOLD_CYCLES = 60;
    localparam logic        CTL_ON      = 1'b1;
    localparam logic        CTL_OFF     = 1'b0;
    localparam dtr_in_t     IDLE_TICK   = '0;

    typedef struct {
        dtr_in_t  w;
        bit       given;
        dtr_out_t want;
    } dir_row_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    dtr_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    dtr_out_t m_data;

    // predictor state
    logic [15:0] sys_cnt;
    logic [7:0]  tima;
    logic [7:0]  tma;
    logic [2:0]  ctl_cur;
    logic [2:0]  ctl_prev;
    logic [1:0]  reload_wait;
    logic [1:0]  wr_block;

    dtr_out_t    pending_ticks[$];
    dir_row_t    dir_rows[$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    bit          ready_hold_req = 1'b0;

    divider_timer_with_reload_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic dtr_in_t tick(input logic dc, input logic cw, input logic [7:0] cd,
                                     input logic mw, input logic [7:0] md,
                                     input logic kw, input logic [2:0] kd);
        dtr_in_t w;
        w.divider_clear = dc;
        w.count_write   = cw;
        w.count_data    = cd;
        w.modulo_write  = mw;
        w.modulo_data   = md;
        w.control_write = kw;
        w.control_data  = kd;
        return w;
    endfunction

    function automatic logic [3:0] tap_of(input logic [2:0] ctl);
        case (dtr_sel_t'(ctl[1:0]))
            SEL_BIT9: return TAP_BIT9;
            SEL_BIT3: return TAP_BIT3;
            SEL_BIT5: return TAP_BIT5;
            SEL_BIT7: return TAP_BIT7;
            default:  return TAP_BIT9;
        endcase
    endfunction

    function automatic void timer_reset();
        sys_cnt     = SYS_RESET;
        tima        = '0;
        tma         = '0;
        ctl_cur     = CONTROL_RESET;
        ctl_prev    = CONTROL_RESET;
        reload_wait = '0;
        wr_block    = '0;
    endfunction

    // one emulated tick; returns the word the block should produce for it
    function automatic dtr_out_t timer_tick(input dtr_in_t w);
        dtr_out_t    r;
        logic [15:0] sys_old;
        logic [7:0]  cnt_old;
        logic        wr_en;
        logic        fired;
        wr_en = w.count_write;
        fired = 1'b0;
        if (w.modulo_write)
            tma = w.modulo_data;
        if (w.control_write)
            ctl_cur = w.control_data;
        sys_old = sys_cnt;
        sys_cnt = (w.divider_clear ? 16'd0 : sys_cnt) + 16'd1;
        cnt_old = tima;
        if (wr_block != 0) begin
            wr_block = wr_block - 2'd1;
            wr_en    = 1'b0;
        end
        if (reload_wait == 2'd1) begin
            reload_wait = '0;
            tima        = tma;
            wr_block    = WRITE_BLOCK_TICKS;
            fired       = 1'b1;
        end else begin
            if (reload_wait != 0)
                reload_wait = reload_wait - 2'd1;
            // bit 2 of control is the enable
            if (ctl_cur[2]) begin
                if (sys_old[tap_of(ctl_prev)] && !sys_cnt[tap_of(ctl_cur)])
                    tima = tima + 8'd1;
            end else if (ctl_prev[2] && sys_cnt[tap_of(ctl_cur)]) begin
                tima = tima + 8'd1;
            end
        end
        if (wr_en) begin
            tima        = w.count_data;
            reload_wait = '0;
        end else if (cnt_old[7] && !tima[7]) begin
            reload_wait = RELOAD_DELAY;
        end
        ctl_prev        = ctl_cur;
        r.divider_value = sys_cnt[15:8];
        r.count_value   = tima;
        r.timer_irq     = fired;
        return r;
    endfunction

    // strobes biased so the counter overflows and reloads often
    function automatic dtr_in_t rand_tick(input int unsigned scale);
        dtr_in_t w;
        w.divider_clear = ($urandom_range(0, 32 * scale - 1) == 0);
        w.count_write   = ($urandom_range(0, 24 * scale - 1) == 0);
        w.count_data    = $urandom_range(0, 1) ? 8'($urandom_range(8'hF8, 8'hFF))
                                               : 8'($urandom);
        w.modulo_write  = ($urandom_range(0, 8 * scale - 1) == 0);
        w.modulo_data   = $urandom_range(0, 1) ? 8'($urandom_range(8'hF0, 8'hFF))
                                               : 8'($urandom);
        w.control_write = ($urandom_range(0, 16 * scale - 1) == 0);
        w.control_data  = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 3) != 0)
            w.control_data[2] = CTL_ON;
        return w;
    endfunction

    task automatic offer_tick(input dtr_in_t w);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_ticks.size() != 0)
            @(posedge aclk);
    endtask

    task automatic check_word(input dtr_out_t got);
        dtr_out_t want;
        if (pending_ticks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected word: div=%h cnt=%h irq=%b",
                         got.divider_value, got.count_value, got.timer_irq);
            return;
        end
        want = pending_ticks.pop_front();
        if (got.divider_value !== want.divider_value || got.count_value !== want.count_value
                || got.timer_irq !== want.timer_irq) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected div=%h cnt=%h irq=%b, got div=%h cnt=%h irq=%b",
                         want.divider_value, want.count_value, want.timer_irq,
                         got.divider_value, got.count_value, got.timer_irq);
        end
    endtask

    // result side
    initial begin
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            if (ready_hold_req) begin
                gap            = HOLD_CYCLES;
                ready_hold_req = 1'b0;
            end else begin
                gap = $urandom_range(0, 5);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            check_word(m_data);
        end
    end

    // stimulus
    initial begin
        dtr_in_t  w;
        dtr_out_t o;

        // reset, then count off a bit-3 overflow made by a divider clear
        dir_rows.push_back('{IDLE_TICK, 1'b1, dtr_out_t'{8'h18, 8'h00, 1'b0}});
        dir_rows.push_back('{tick(1'b1, 1'b1, 8'hFF, 1'b0, 8'h00, 1'b0, 3'd0), 1'b1,
                             dtr_out_t'{8'h00, 8'hFF, 1'b0}});
        dir_rows.push_back('{tick(1'b0, 1'b0, 8'h00, 1'b1, 8'hAB, 1'b1, {CTL_ON, SEL_BIT3}),
                             1'b0, '0});
        dir_rows.push_back('{tick(1'b0, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 3'd0), 1'b0, '0});
        dir_rows.push_back('{tick(1'b0, 1'b1, 8'hFF, 1'b0, 8'h00, 1'b0, 3'd0), 1'b0, '0});
        // data with strobes low must be ignored
        dir_rows.push_back('{tick(1'b0, 1'b0, 8'hFF, 1'b0, 8'hFF, 1'b0, 3'd7), 1'b0, '0});
        repeat (3) dir_rows.push_back('{IDLE_TICK, 1'b0, '0});
        // divider clear drops bit 3: 0xFF wraps, reload pending
        dir_rows.push_back('{tick(1'b1, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 3'd0), 1'b0, '0});
        repeat (2) dir_rows.push_back('{IDLE_TICK, 1'b0, '0});
        // count write on the reload tick replaces the modulo, irq still fires
        dir_rows.push_back('{tick(1'b0, 1'b1, 8'h55, 1'b0, 8'h00, 1'b0, 3'd0), 1'b1,
                             dtr_out_t'{8'h00, 8'h55, 1'b1}});
        dir_rows.push_back('{tick(1'b0, 1'b1, 8'h12, 1'b0, 8'h00, 1'b0, 3'd0), 1'b0, '0});
        repeat (2) dir_rows.push_back('{IDLE_TICK, 1'b0, '0});
        // disable while the selected bit is high
        dir_rows.push_back('{tick(1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1, {CTL_OFF, SEL_BIT3}),
                             1'b0, '0});
        // re-enable on another select: old bit from old select
        dir_rows.push_back('{tick(1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1, {CTL_ON, SEL_BIT7}),
                             1'b0, '0});
        dir_rows.push_back('{tick(1'b0, 1'b1, 8'hFF, 1'b0, 8'h00, 1'b0, 3'd0), 1'b0, '0});
        dir_rows.push_back('{tick(1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1, {CTL_ON, SEL_BIT3}),
                             1'b0, '0});
        dir_rows.push_back('{tick(1'b1, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 3'd0), 1'b0, '0});
        // count write cancels the pending reload
        dir_rows.push_back('{tick(1'b0, 1'b1, 8'h80, 1'b0, 8'h00, 1'b0, 3'd0), 1'b0, '0});
        repeat (3) dir_rows.push_back('{IDLE_TICK, 1'b0, '0});

        timer_reset();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            offer_tick(dir_rows[i].w);
            o = timer_tick(dir_rows[i].w);
            pending_ticks.push_back(dir_rows[i].given ? dir_rows[i].want : o);
        end
        drain();

        for (int i = 0; i < 700; i++) begin
            if (i == 300)
                ready_hold_req = 1'b1;
            w = rand_tick(1);
            offer_tick(w);
            pending_ticks.push_back(timer_tick(w));
        end
        drain();

        for (int i = 0; i < 650; i++) begin
            if (i == 200)
                ready_hold_req = 1'b1;
            w = rand_tick(1);
            offer_tick(w);
            pending_ticks.push_back(timer_tick(w));
        end
        drain();
        repeat (10) @(posedge aclk);

        if (mismatches == 0 && pending_ticks.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
